>>> hw/rtl/mapool_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the max/average pooling block.
// No dependencies; every other file of the block imports this package.
package mapool_pkg;

  localparam int SampleW       = 16;
  localparam int KernelRowsMax = 4;
  localparam int RowWidthMax   = 256;
  localparam int DimLimit      = 4096;
  localparam int QueueDepth    = 2;

  localparam int SlotW      = (KernelRowsMax > 1) ? $clog2(KernelRowsMax) : 1;
  localparam int ColW       = $clog2(RowWidthMax);
  localparam int StoreDepth = KernelRowsMax * RowWidthMax;
  localparam int AddrW      = $clog2(StoreDepth);

  // Register field widths
  localparam int DimW     = 13;
  localparam int RowW     = 12;
  localparam int ChanW    = 12;
  localparam int WidthW   = 9;
  localparam int KhW      = 3;
  localparam int KwW      = 9;
  localparam int StrideW  = 9;
  localparam int DivisorW = KhW + KwW;

  // Window sum: up to StoreDepth samples
  localparam int AccW = SampleW + AddrW + 1;

  localparam int PaddrW = 5;

  typedef enum logic [2:0] {
    RegInHeight     = 3'd0,
    RegInWidth      = 3'd1,
    RegChannelCount = 3'd2,
    RegKernelH      = 3'd3,
    RegKernelW      = 3'd4,
    RegStrideLen    = 3'd5,
    RegMaxMode      = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkWalk,
    BkDrain,
    BkDivide,
    BkHold
  } back_state_e;

  // Effective geometry after clamping of the configuration registers
  typedef struct packed {
    logic [DimW-1:0]     h;
    logic [WidthW-1:0]   w;
    logic [DimW-1:0]     ch;
    logic [KhW-1:0]      kh;
    logic [KwW-1:0]      kw;
    logic [StrideW-1:0]  st;
    logic [DivisorW-1:0] divisor;
    logic                max_mode;
  } geom_t;

  // One pending window: bottom-right corner and end-of-tensor flag
  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [ColW-1:0]  col;
    logic             last;
  } job_t;

  typedef struct packed {
    logic               en;
    logic [AddrW-1:0]   addr;
    logic [SampleW-1:0] data;
  } store_wr_t;

endpackage

>>> hw/rtl/mapool_front.sv
`timescale 1ns / 1ps
// Front end: accepts samples, tracks the raster position, writes the line store
// and queues a request for every completed window. Depends on mapool_pkg.
module mapool_front #(
  parameter int QUEUE_DEPTH = mapool_pkg::QueueDepth
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  mapool_pkg::geom_t                       geom_i,
  input  logic                                    restart_i,
  input  logic [mapool_pkg::SampleW-1:0]          sample_i,
  input  logic                                    sample_valid_i,
  output logic                                    sample_stall_o,
  output mapool_pkg::store_wr_t                   wr_o,
  output mapool_pkg::job_t                        job_o,
  output logic                                    push_o,
  input  logic                                    full_i,
  input  mapool_pkg::job_t [QUEUE_DEPTH-1:0]      pend_i,
  input  logic [QUEUE_DEPTH-1:0]                  pend_vld_i
);
  import mapool_pkg::*;

  localparam int GapW = SlotW + 1;
  localparam int CmpW = KhW + GapW;
  localparam int CW   = KwW + 1;
  localparam int RW   = DimW;
  localparam int SW   = StrideW + 1;

  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [ChanW-1:0]   chan_q, chan_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [StrideW-1:0] rph_q, rph_d;
  logic [StrideW-1:0] cph_q, cph_d;

  logic [RW-1:0]      row_inc;
  logic [CW-1:0]      col_inc;
  logic [RW-1:0]      chan_inc;
  logic               accept;
  logic               win;
  logic               last;
  logic               hazard;
  logic [GapW-1:0]    slot_gap [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit;

  assign row_inc  = RW'(row_q) + RW'(1);
  assign col_inc  = CW'(col_q) + CW'(1);
  assign chan_inc = RW'(chan_q) + RW'(1);

  // Hold off a write that would land inside a window still waiting to be read
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (pend_i[k].slot >= slot_q) begin
        slot_gap[k] = GapW'(pend_i[k].slot) - GapW'(slot_q);
      end else begin
        slot_gap[k] = GapW'(pend_i[k].slot) + GapW'(KernelRowsMax) - GapW'(slot_q);
      end
      hit[k] = pend_vld_i[k] &&
               (CmpW'(slot_gap[k]) < CmpW'(geom_i.kh)) &&
               (col_q <= pend_i[k].col) &&
               (CW'(col_q) + CW'(geom_i.kw) > CW'(pend_i[k].col));
    end
  end

  assign hazard         = |hit;
  assign sample_stall_o = full_i | hazard;
  assign accept         = sample_valid_i & ~sample_stall_o;

  assign win  = (row_inc >= RW'(geom_i.kh)) && (col_inc >= CW'(geom_i.kw)) &&
                (rph_q == '0) && (cph_q == '0);
  assign last = (chan_inc == geom_i.ch) &&
                (RW'(row_q) + RW'(geom_i.st) >= geom_i.h) &&
                (CW'(col_q) + CW'(geom_i.st) >= CW'(geom_i.w));

  assign wr_o.en   = accept;
  assign wr_o.addr = AddrW'(slot_q) * AddrW'(RowWidthMax) + AddrW'(col_q);
  assign wr_o.data = sample_i;

  assign job_o.slot = slot_q;
  assign job_o.col  = col_q;
  assign job_o.last = last;
  assign push_o     = accept & win;

  // Advance the raster position and the stride phases
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    chan_d = chan_q;
    slot_d = slot_q;
    rph_d  = rph_q;
    cph_d  = cph_q;
    if (restart_i) begin
      row_d  = '0;
      col_d  = '0;
      chan_d = '0;
      slot_d = '0;
      rph_d  = '0;
      cph_d  = '0;
    end else if (accept) begin
      if (col_inc >= CW'(geom_i.w)) begin
        col_d = '0;
        cph_d = '0;
        if (row_inc >= geom_i.h) begin
          row_d  = '0;
          slot_d = '0;
          rph_d  = '0;
          chan_d = (chan_inc >= geom_i.ch) ? '0 : chan_inc[ChanW-1:0];
        end else begin
          row_d  = row_inc[RowW-1:0];
          slot_d = (slot_q == SlotW'(KernelRowsMax - 1)) ? '0 : slot_q + 1'b1;
          if (row_inc + RW'(1) <= RW'(geom_i.kh)) begin
            rph_d = '0;
          end else begin
            rph_d = (SW'(rph_q) + SW'(1) == SW'(geom_i.st)) ? '0 : rph_q + 1'b1;
          end
        end
      end else begin
        col_d = col_inc[ColW-1:0];
        if (col_inc + CW'(1) <= CW'(geom_i.kw)) begin
          cph_d = '0;
        end else begin
          cph_d = (SW'(cph_q) + SW'(1) == SW'(geom_i.st)) ? '0 : cph_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      chan_q <= '0;
      slot_q <= '0;
      rph_q  <= '0;
      cph_q  <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      chan_q <= chan_d;
      slot_q <= slot_d;
      rph_q  <= rph_d;
      cph_q  <= cph_d;
    end
  end

endmodule

>>> hw/rtl/mapool_queue.sv
`timescale 1ns / 1ps
// Short shift queue of window requests between front and back end.
// Depends on mapool_pkg; the head always sits in entry 0.
module mapool_queue #(
  parameter int DEPTH = mapool_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  mapool_pkg::job_t                  job_i,
  input  logic                              pop_i,
  output mapool_pkg::job_t                  head_o,
  output logic                              empty_o,
  output logic                              full_o,
  output mapool_pkg::job_t [DEPTH-1:0]      ent_o,
  output logic [DEPTH-1:0]                  vld_o
);
  import mapool_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  job_t [DEPTH-1:0] ent_q, ent_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  wr_idx;

  assign wr_idx = cnt_q - CntW'(pop_i);
  assign cnt_d  = cnt_q + CntW'(push_i) - CntW'(pop_i);

  always_comb begin
    ent_d = ent_q;
    // shift toward the head on pop
    if (pop_i) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        ent_d[k] = ent_q[k + 1];
      end
    end
    for (int k = 0; k < DEPTH; k++) begin
      if (push_i && (wr_idx == CntW'(k))) begin
        ent_d[k] = job_i;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      vld_o[k] = CntW'(k) < cnt_q;
    end
  end

  assign head_o  = ent_q[0];
  assign ent_o   = ent_q;
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/mapool_div.sv
`timescale 1ns / 1ps
// Restoring divider for the window mean, one quotient bit per cycle.
// Depends on mapool_pkg; quotient is truncated toward zero.
module mapool_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [mapool_pkg::AccW-1:0]        dividend_i,
  input  logic [mapool_pkg::DivisorW-1:0]    divisor_i,
  output logic                               done_o,
  output logic [mapool_pkg::SampleW-1:0]     quotient_o
);
  import mapool_pkg::*;

  localparam int CntW = $clog2(AccW);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [AccW-1:0]     quo_q;
  logic [DivisorW-1:0] rem_q;
  logic [DivisorW-1:0] dvs_q;
  logic                neg_q;

  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;
  logic                take;
  logic [AccW-1:0]     q_signed;

  assign trial = {rem_q, quo_q[AccW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = trial >= {1'b0, dvs_q};

  assign q_signed   = neg_q ? (~quo_q + AccW'(1)) : quo_q;
  assign quotient_o = q_signed[SampleW-1:0];
  assign done_o     = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(AccW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Divide the magnitude, restore the sign at the output
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[AccW-1];
      quo_q <= dividend_i[AccW-1] ? (~dividend_i + AccW'(1)) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[AccW-2:0], take};
      rem_q <= take ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    end
  end

endmodule

>>> hw/rtl/mapool_back.sv
`timescale 1ns / 1ps
// Back end: holds the line store, walks each queued window one sample per
// cycle, reduces it to max or mean and holds the result. Depends on mapool_pkg.
module mapool_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mapool_pkg::geom_t                      geom_i,
  input  mapool_pkg::store_wr_t                  wr_i,
  input  mapool_pkg::job_t                       head_i,
  input  logic                                   empty_i,
  output logic                                   pop_o,
  output logic signed [mapool_pkg::SampleW-1:0]  pooled_o,
  output logic                                   out_last_o,
  output logic                                   pooled_valid_o,
  input  logic                                   pooled_stall_i
);
  import mapool_pkg::*;

  localparam int IW = (SlotW > KhW) ? SlotW : KhW;

  logic [SampleW-1:0] mem [StoreDepth];
  logic [SampleW-1:0] rd_q;
  logic [AddrW-1:0]   rd_addr;

  back_state_e state_q, state_d;
  logic               rd_vld_q, rd_vld_d;

  logic [SlotW-1:0]   slot_q;
  logic [ColW-1:0]    col_q;
  logic [ColW-1:0]    base_col_q;
  logic [SlotW-1:0]   i_q;
  logic [KwW-1:0]     j_q;
  logic               last_q;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [SampleW-1:0] best_q, best_d;
  logic [SampleW-1:0] res_q;

  logic               col_end;
  logic               row_end;
  logic               walk_end;
  logic               div_start;
  logic               div_done;
  logic [SampleW-1:0] div_q;
  logic [AccW-1:0]    rd_ext;

  assign rd_addr  = AddrW'(slot_q) * AddrW'(RowWidthMax) + AddrW'(col_q);
  assign col_end  = (j_q == geom_i.kw - 1'b1);
  assign row_end  = (IW'(i_q) == IW'(geom_i.kh - 1'b1));
  assign walk_end = col_end & row_end;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_ext = {{(AccW - SampleW){rd_q[SampleW-1]}}, rd_q};

  always_comb begin
    acc_d  = acc_q;
    best_d = best_q;
    if (rd_vld_q) begin
      acc_d = acc_q + rd_ext;
      if ($signed(rd_q) > $signed(best_q)) begin
        best_d = rd_q;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (!empty_i) begin
          state_d = BkWalk;
        end
      end
      BkWalk: begin
        if (walk_end) begin
          state_d = BkDrain;
        end
      end
      BkDrain: begin
        state_d = geom_i.max_mode ? BkHold : BkDivide;
      end
      BkDivide: begin
        if (div_done) begin
          state_d = BkHold;
        end
      end
      BkHold: begin
        if (!pooled_stall_i) begin
          state_d = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_comb begin
    pop_o          = 1'b0;
    div_start      = 1'b0;
    rd_vld_d       = 1'b0;
    pooled_valid_o = 1'b0;
    case (state_q)
      BkWalk: begin
        rd_vld_d = 1'b1;
        // release the request once its last read is issued
        pop_o    = walk_end;
      end
      BkDrain: begin
        div_start = ~geom_i.max_mode;
      end
      BkHold: begin
        pooled_valid_o = 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BkIdle;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkIdle) begin
      acc_q      <= '0;
      best_q     <= {1'b1, {(SampleW - 1){1'b0}}};
      slot_q     <= head_i.slot;
      col_q      <= head_i.col;
      base_col_q <= head_i.col;
      last_q     <= head_i.last;
      i_q        <= '0;
      j_q        <= '0;
    end else begin
      acc_q  <= acc_d;
      best_q <= best_d;
      if (state_q == BkWalk) begin
        if (col_end) begin
          // step up one row, back to the right edge of the window
          j_q    <= '0;
          col_q  <= base_col_q;
          i_q    <= i_q + 1'b1;
          slot_q <= (slot_q == '0) ? SlotW'(KernelRowsMax - 1) : slot_q - 1'b1;
        end else begin
          j_q   <= j_q + 1'b1;
          col_q <= col_q - 1'b1;
        end
      end
    end
    if ((state_q == BkDrain) && geom_i.max_mode) begin
      res_q <= best_d;
    end else if ((state_q == BkDivide) && div_done) begin
      res_q <= div_q;
    end
  end

  mapool_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_d),
    .divisor_i  (geom_i.divisor),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign pooled_o   = res_q;
  assign out_last_o = last_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("window request released from an empty queue");

  a_no_write_into_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkWalk && wr_i.en) |-> (wr_i.addr != rd_addr))
    else $error("line store written inside the window being read");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkHold && pooled_stall_i) |=>
      (state_q == BkHold && $stable(res_q) && $stable(last_q)))
    else $error("held result changed while stalled");

  a_div_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == BkDivide))
    else $error("divider finished outside of the divide state");

endmodule

>>> hw/rtl/max_avg_pooling_2d_top.sv
`timescale 1ns / 1ps
// 2-D max / average pooling over a streamed tensor.
// Samples enter on sample_i with sample_valid_i / sample_stall_o, one per
// accepted request, in channel, row, column order. Window results leave on
// pooled_o / out_last_o with pooled_valid_o / pooled_stall_i; out_last_o marks
// the final window of the tensor. Geometry and mode sit in APB registers; any
// register write restarts the tensor at row 0, column 0, channel 0.
// Throughput: one sample per cycle until the two-entry request queue fills or a
// sample would overwrite a pending window. Each window is read back from the
// line store one sample per cycle, then goes through the bit-serial divider for
// average pooling; the front end keeps taking samples meanwhile.
// A stalled result holds in its output register; the front end keeps going.
// Reset clears the position counters and queue and sets every register to 1,
// except stride_len and max_mode to 0. The line store is not cleared.
module max_avg_pooling_2d_top #(
  parameter int QUEUE_DEPTH = mapool_pkg::QueueDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mapool_pkg::PaddrW-1:0]          paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic signed [mapool_pkg::SampleW-1:0]  sample_i,
  input  logic                                   sample_valid_i,
  output logic                                   sample_stall_o,
  output logic signed [mapool_pkg::SampleW-1:0]  pooled_o,
  output logic                                   out_last_o,
  output logic                                   pooled_valid_o,
  input  logic                                   pooled_stall_i
);
  import mapool_pkg::*;

  logic [DimW-1:0]    in_height_q;
  logic [WidthW-1:0]  in_width_q;
  logic [DimW-1:0]    channel_count_q;
  logic [KhW-1:0]     kernel_h_q;
  logic [KwW-1:0]     kernel_w_q;
  logic [StrideW-1:0] stride_len_q;
  logic               max_mode_q;

  logic [2:0]         reg_idx;
  logic               cfg_wr;
  logic               restart;
  geom_t              geom;

  store_wr_t          wr;
  job_t               job;
  job_t               head;
  job_t [QUEUE_DEPTH-1:0] pend;
  logic [QUEUE_DEPTH-1:0] pend_vld;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign restart = cfg_wr && (reg_idx <= RegMaxMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q     <= DimW'(1);
      in_width_q      <= WidthW'(1);
      channel_count_q <= DimW'(1);
      kernel_h_q      <= KhW'(1);
      kernel_w_q      <= KwW'(1);
      stride_len_q    <= '0;
      max_mode_q      <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegInHeight:     in_height_q     <= pwdata[DimW-1:0];
        RegInWidth:      in_width_q      <= pwdata[WidthW-1:0];
        RegChannelCount: channel_count_q <= pwdata[DimW-1:0];
        RegKernelH:      kernel_h_q      <= pwdata[KhW-1:0];
        RegKernelW:      kernel_w_q      <= pwdata[KwW-1:0];
        RegStrideLen:    stride_len_q    <= pwdata[StrideW-1:0];
        RegMaxMode:      max_mode_q      <= pwdata[0];
        default: begin
          max_mode_q <= max_mode_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegInHeight:     prdata = 32'(in_height_q);
      RegInWidth:      prdata = 32'(in_width_q);
      RegChannelCount: prdata = 32'(channel_count_q);
      RegKernelH:      prdata = 32'(kernel_h_q);
      RegKernelW:      prdata = 32'(kernel_w_q);
      RegStrideLen:    prdata = 32'(stride_len_q);
      RegMaxMode:      prdata = 32'(max_mode_q);
      default:         prdata = '0;
    endcase
  end

  // Clamp the register values to the geometry the datapath works with
  always_comb begin
    if (in_height_q == '0) begin
      geom.h = DimW'(1);
    end else if (in_height_q > DimW'(DimLimit)) begin
      geom.h = DimW'(DimLimit);
    end else begin
      geom.h = in_height_q;
    end
    if (in_width_q == '0) begin
      geom.w = WidthW'(1);
    end else if (in_width_q > WidthW'(RowWidthMax)) begin
      geom.w = WidthW'(RowWidthMax);
    end else begin
      geom.w = in_width_q;
    end
    if (channel_count_q == '0) begin
      geom.ch = DimW'(1);
    end else if (channel_count_q > DimW'(DimLimit)) begin
      geom.ch = DimW'(DimLimit);
    end else begin
      geom.ch = channel_count_q;
    end
    if (kernel_h_q == '0) begin
      geom.kh = KhW'(1);
    end else if (kernel_h_q > KhW'(KernelRowsMax)) begin
      geom.kh = KhW'(KernelRowsMax);
    end else begin
      geom.kh = kernel_h_q;
    end
    geom.kw       = (kernel_w_q == '0) ? KwW'(1) : kernel_w_q;
    geom.st       = (stride_len_q == '0) ? StrideW'(geom.kh) : stride_len_q;
    geom.divisor  = DivisorW'(geom.kh) * DivisorW'(geom.kw);
    geom.max_mode = max_mode_q;
  end

  mapool_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .geom_i         (geom),
    .restart_i      (restart),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .wr_o           (wr),
    .job_o          (job),
    .push_o         (push),
    .full_i         (full),
    .pend_i         (pend),
    .pend_vld_i     (pend_vld)
  );

  mapool_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full),
    .ent_o   (pend),
    .vld_o   (pend_vld)
  );

  mapool_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .geom_i         (geom),
    .wr_i           (wr),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .pooled_o       (pooled_o),
    .out_last_o     (out_last_o),
    .pooled_valid_o (pooled_valid_o),
    .pooled_stall_i (pooled_stall_i)
  );

endmodule

>>> tb/max_avg_pooling_2d_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for max_avg_pooling_2d_top: streams samples over
// many geometries and compares every pooled window with a built-in predictor.
// Depends on mapool_pkg and the max_avg_pooling_2d_top RTL only.
module max_avg_pooling_2d_top_test;
  import mapool_pkg::*;

  localparam int unsigned RandomItems  = 1400;
  // Longest window walk plus divider, with margin
  localparam int unsigned SettleCycles = KernelRowsMax * RowWidthMax + 40;
  // Every item as a full-size average window behind a long stall, times four
  localparam int unsigned CycleLimit   = 6_000_000;
  localparam int unsigned PrintCap     = 200;
  localparam logic signed [SampleW-1:0] MostNeg = {1'b1, {(SampleW - 1){1'b0}}};
  localparam logic signed [SampleW-1:0] MostPos = {1'b0, {(SampleW - 1){1'b1}}};

  typedef struct {
    logic [SampleW-1:0] pooled;
    logic               last;
  } window_t;

  typedef enum logic [1:0] {
    StallNone,
    StallSparse,
    StallRuns,
    StallToggle
  } stall_style_e;

  // Predicts pooled windows from accepted samples and checks the results.
  class pooling_scoreboard;
    logic [DimW-1:0]    in_height;
    logic [WidthW-1:0]  in_width;
    logic [DimW-1:0]    channel_count;
    logic [KhW-1:0]     kernel_h;
    logic [KwW-1:0]     kernel_w;
    logic [StrideW-1:0] stride_len;
    logic               max_mode;
    logic signed [SampleW-1:0] line_rows [StoreDepth];
    int unsigned row_pos, col_pos, chan_pos;
    window_t     windows_due[$];
    int unsigned errors, samples_seen, windows_checked;

    function new();
      in_height       = 1;
      in_width        = 1;
      channel_count   = 1;
      kernel_h        = 1;
      kernel_w        = 1;
      stride_len      = 0;
      max_mode        = 1'b0;
      row_pos         = 0;
      col_pos         = 0;
      chan_pos        = 0;
      errors          = 0;
      samples_seen    = 0;
      windows_checked = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int unsigned pending();
      return windows_due.size();
    endfunction

    // Any register write restarts the tensor.
    function void load_reg(cfg_reg_e idx, logic [31:0] value);
      case (idx)
        RegInHeight:     in_height     = value[DimW-1:0];
        RegInWidth:      in_width      = value[WidthW-1:0];
        RegChannelCount: channel_count = value[DimW-1:0];
        RegKernelH:      kernel_h      = value[KhW-1:0];
        RegKernelW:      kernel_w      = value[KwW-1:0];
        RegStrideLen:    stride_len    = value[StrideW-1:0];
        RegMaxMode:      max_mode      = value[0];
        default: ;
      endcase
      row_pos  = 0;
      col_pos  = 0;
      chan_pos = 0;
    endfunction

    function void absorb_sample(logic signed [SampleW-1:0] s);
      int unsigned h, w, ch, kh, kw, st, r, c, slot, i, j;
      longint acc, best, v;
      window_t win;
      h  = clamp_dim(in_height, DimLimit);
      w  = clamp_dim(in_width, RowWidthMax);
      ch = clamp_dim(channel_count, DimLimit);
      kh = clamp_dim(kernel_h, KernelRowsMax);
      kw = (kernel_w == 0) ? 1 : kernel_w;
      st = (stride_len == 0) ? kh : stride_len;
      if (row_pos >= h) row_pos = 0;
      if (col_pos >= w) col_pos = 0;
      if (chan_pos >= ch) chan_pos = 0;
      r = row_pos;
      c = col_pos;
      line_rows[(r % KernelRowsMax) * RowWidthMax + c] = s;
      samples_seen++;

      // Bottom-right corner of a window on the stride grid
      if (r + 1 >= kh && c + 1 >= kw &&
          (r + 1 - kh) % st == 0 && (c + 1 - kw) % st == 0) begin
        acc  = 0;
        best = MostNeg;
        for (i = 0; i < kh; i++) begin
          slot = (r - i) % KernelRowsMax;
          for (j = 0; j < kw; j++) begin
            v = line_rows[slot * RowWidthMax + c - j];
            acc += v;
            if (v > best) best = v;
          end
        end
        if (!max_mode) best = acc / longint'(kh * kw);
        win.pooled = best[SampleW-1:0];
        win.last   = (chan_pos + 1 == ch) && (r + st >= h) && (c + st >= w);
        windows_due.push_back(win);
      end

      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) begin
          row_pos = 0;
          chan_pos++;
          if (chan_pos >= ch) chan_pos = 0;
        end
      end
    endfunction

    function void check_window(logic [SampleW-1:0] pooled, logic last);
      window_t want;
      if (windows_due.size() == 0) begin
        errors++;
        if (errors <= PrintCap)
          $display("%0t: unexpected window: pooled %0d, last %0b",
                   $time, $signed(pooled), last);
        return;
      end
      want = windows_due.pop_front();
      windows_checked++;
      if (pooled !== want.pooled) begin
        errors++;
        if (errors <= PrintCap)
          $display("%0t: pooled mismatch: expected %0d, actual %0d",
                   $time, $signed(want.pooled), $signed(pooled));
      end
      if (last !== want.last) begin
        errors++;
        if (errors <= PrintCap)
          $display("%0t: out_last mismatch: expected %0b, actual %0b",
                   $time, want.last, last);
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PaddrW-1:0]         paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;
  logic signed [SampleW-1:0] sample_i;
  logic                      sample_valid_i;
  logic                      sample_stall_o;
  logic signed [SampleW-1:0] pooled_o;
  logic                      out_last_o;
  logic                      pooled_valid_o;
  logic                      pooled_stall_i;

  pooling_scoreboard sb;
  int unsigned  cycle_count = 0;
  int unsigned  geometries = 0;
  bit           drained_mid_stream = 1'b0;
  stall_style_e stall_style = StallNone;
  int unsigned  stall_run = 0;

  max_avg_pooling_2d_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .pooled_o       (pooled_o),
    .out_last_o     (out_last_o),
    .pooled_valid_o (pooled_valid_o),
    .pooled_stall_i (pooled_stall_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stall: switch between randomly chosen stall styles
  always @(posedge clk_i) begin
    logic hold;
    hold = 1'b0;
    if (rst_ni) begin
      if (cycle_count % 512 == 0) stall_style = stall_style_e'($urandom_range(0, 3));
      case (stall_style)
        StallSparse: hold = ($urandom_range(0, 2) == 0);
        StallRuns: begin
          if (stall_run != 0) begin
            stall_run--;
            hold = 1'b1;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_run = $urandom_range(4, 19);
            hold = 1'b1;
          end
        end
        StallToggle: hold = cycle_count[0];
        default: hold = 1'b0;
      endcase
    end
    pooled_stall_i <= hold;
  end

  // Outputs and inputs only move at rising edges, so the falling edge sees
  // exactly what the next rising edge will accept.
  always @(negedge clk_i) begin
    if (rst_ni && pooled_valid_o && !pooled_stall_i) sb.check_window(pooled_o, out_last_o);
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    sb.load_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait out every pending window, then the back end's worst latency.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_geometry(input logic [31:0] h, w, ch, kh, kw, st, mm);
    settle();
    write_reg(RegInHeight, h);
    write_reg(RegInWidth, w);
    write_reg(RegChannelCount, ch);
    write_reg(RegKernelH, kh);
    write_reg(RegKernelW, kw);
    write_reg(RegStrideLen, st);
    write_reg(RegMaxMode, mm);
    geometries++;
  endtask

  // Hold the request until accepted; valid stays high for the next one.
  task automatic send_sample(input logic signed [SampleW-1:0] value);
    sample_i       <= value;
    sample_valid_i <= 1'b1;
    @(negedge clk_i);
    while (sample_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    sb.absorb_sample(value);
  endtask

  task automatic stop_sending();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] random_sample();
    logic [31:0] raw;
    raw = $urandom();
    if (raw[31:29] == 3'b000) begin
      case (raw[1:0])
        2'd0: return MostNeg;
        2'd1: return MostPos;
        2'd2: return '0;
        default: return '1;
      endcase
    end
    return raw[SampleW-1:0];
  endfunction

  task automatic stream_samples(input int unsigned count);
    int unsigned sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 48);
      while (burst != 0 && sent < count) begin
        send_sample(random_sample());
        sent++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0 && sent < count) begin
        sample_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        // Now and then hold off until every window is out
        if (!drained_mid_stream || $urandom_range(0, 15) == 0) begin
          drained_mid_stream = 1'b1;
          while (sb.pending() != 0) @(posedge clk_i);
        end
      end
    end
    stop_sending();
  endtask

  initial begin
    int unsigned random_items, n, pick;
    logic [31:0] g_h, g_w, g_ch, g_kh, g_kw, g_st, g_mm;
    sb = new();
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    sample_i       <= '0;
    sample_valid_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: 1x1 average, every sample is its own last window
    send_sample(MostNeg);
    send_sample(MostPos);
    send_sample('0);
    send_sample('1);
    stop_sending();

    // Max of an all-minimum window
    apply_geometry(2, 2, 1, 2, 2, 0, 1);
    repeat (4) send_sample(MostNeg);
    stop_sending();

    // Mean truncation both ways, tensor wraps between the two windows
    apply_geometry(2, 2, 1, 2, 2, 0, 0);
    send_sample(MostPos);
    send_sample(MostPos);
    send_sample(MostPos);
    send_sample(MostNeg);
    send_sample(MostNeg);
    send_sample(MostNeg);
    send_sample(MostNeg);
    send_sample(MostPos);
    stop_sending();

    // Zero sizes act as one
    apply_geometry(0, 0, 0, 0, 0, 0, 1);
    send_sample(random_sample());
    send_sample(random_sample());
    stop_sending();

    // Kernel wider than the row: nothing comes out
    apply_geometry(1, 2, 1, 1, 3, 0, 0);
    repeat (3) send_sample(random_sample());
    stop_sending();

    random_items = 0;
    while (random_items < RandomItems) begin
      pick = (geometries < 8) ? geometries - 5 : $urandom_range(3, 19);
      g_h  = $urandom_range(1, 6);
      g_w  = $urandom_range(1, 10);
      g_ch = $urandom_range(1, 3);
      g_kh = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      g_kw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
      g_st = $urandom_range(0, 4);
      g_mm = $urandom_range(0, 1);
      n    = $urandom_range(16, 100);
      case (pick)
        0: begin
          // All-ones registers: sizes saturate, kernel never fits
          g_h  = 13'h1FFF;
          g_w  = 9'h1FF;
          g_ch = 13'h1FFF;
          g_kh = 3'h7;
          g_kw = 9'h1FF;
          g_st = 9'h1FF;
          n    = 40;
        end
        1: begin
          // Largest sizes: full-width row and a full-width, one-row kernel
          g_h  = DimLimit;
          g_w  = RowWidthMax;
          g_ch = DimLimit;
          g_kh = 1;
          g_kw = RowWidthMax;
          g_st = RowWidthMax;
          n    = 260;
        end
        2: begin
          // Tall, wide average window
          g_h  = KernelRowsMax;
          g_w  = 32;
          g_ch = 2;
          g_kh = KernelRowsMax;
          g_kw = 32;
          g_st = 0;
          g_mm = 0;
          n    = 256;
        end
        3: begin
          g_h  = 0;
          g_w  = 0;
          g_ch = 0;
          g_kh = 0;
          g_kw = 0;
        end
        4: begin
          if ($urandom_range(0, 1) == 0) g_kw = g_w + $urandom_range(1, 3);
          else g_h = (g_kh > 1 && g_kh < 5) ? g_kh - 1 : 1;
          if (g_kh < 2 || g_kh > 4) g_kh = 4;
        end
        default: ;
      endcase
      apply_geometry(g_h, g_w, g_ch, g_kh, g_kw, g_st, g_mm);
      stream_samples(n);
      random_items += n;
    end

    settle();
    $display("Streamed %0d samples over %0d geometries; %0d pooled windows checked.",
             sb.samples_seen, geometries + 1, sb.windows_checked);
    $display("Max and average modes, clamped and zero sizes, random gaps and stalls.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
